>>> rtl/stereo_correlation_width_meter_assert.svh
// Assertion macros for the stereo meter checker.
`ifndef STEREO_CORRELATION_WIDTH_METER_ASSERT_SVH
`define STEREO_CORRELATION_WIDTH_METER_ASSERT_SVH

// Concurrent assertion sampled on clk, disabled while rst_n is low.
`define SCWM_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Concurrent assertion sampled on clk that also covers reset cycles.
`define SCWM_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

>>> rtl/scwm_pkg.sv
// Package with constants shared by the stereo correlation and width meter.
package scwm_pkg;

    // Fixed port field widths
    localparam int FIELD_BITS = 24;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 40;
    localparam int WIDTH_W    = 17;
    localparam int CORR_W     = 18;

    // Arithmetic sizes
    localparam int SUM_W   = 64;
    localparam int DIGIT_W = 4;

    // Configuration register indexes
    localparam logic [1:0] REG_WINDOW = 2'd0;
    localparam logic [1:0] REG_UPDATE = 2'd1;
    localparam logic [1:0] REG_MONO   = 2'd2;

    // Input commands
    localparam logic CMD_FRAME = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    // Register reset values and the Q16 unit
    localparam logic [14:0]        WINDOW_RESET = 15'd14400;
    localparam logic [15:0]        UPDATE_RESET = 16'd4800;
    localparam logic [WIDTH_W-1:0] ONE_Q16      = 17'h10000;

endpackage

>>> rtl/stereo_correlation_width_meter.sv
// Top level of the sliding-window stereo correlation and width meter.
// Usage:
//   s_axis carries one request per audio frame: tuser = command (clear or
//   frame), tdata = left and right samples. m_axis carries a measurement
//   every update_frames frames: tuser flags, tdata width and correlation.
//   The cfg channel writes window_frames, update_frames and mono_mode; it is
//   always ready, and the user must write it only while the block is idle;
//   the block itself does not enforce this.
// Sequence (24-bit samples, 4-bit digits, 7 digit steps per product):
//   a frame runs a ring read, six digit-serial products and the counter
//   check. A frame that emits a result adds, where needed, a 16-step divide,
//   a 16-digit 64x64 product, a 64-step square root and a 16-step divide.
// Reset, a window_frames write and a clear request run a clearing pass over
//   all WINDOW_DEPTH entries of the sample ring; no request is taken meanwhile.
// The result waits in an output register; a stalled receiver does not stop
//   the next frame, which waits only at its own result if the slot is full.
module stereo_correlation_width_meter #(
    parameter int WINDOW_DEPTH = 16384,
    parameter int SAMPLE_BITS  = 24
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [scwm_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // left_sample, right_sample
    input  logic [0:0]                       s_axis_tuser,  // command
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [scwm_pkg::OUT_DATA_W-1:0]  m_axis_tdata,  // stereo_width, correlation
    output logic [1:0]                       m_axis_tuser,  // width_valid, correlation_valid
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [1:0]                       i_cfg_index,
    input  logic [15:0]                      i_cfg_data
);

    localparam int AW   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int LW   = $clog2(WINDOW_DEPTH + 1);
    localparam int CW   = (LW > 15) ? LW : 15;
    localparam int OPW  = SAMPLE_BITS + 3;
    localparam int PW   = 2 * OPW;
    localparam int DW   = scwm_pkg::DIGIT_W;
    localparam int NDIG = (OPW + DW - 1) / DW;
    localparam int SW   = scwm_pkg::SUM_W;
    localparam int WIDE_STEPS = SW / DW;

    // Product sequence codes
    localparam logic [2:0] P_LEFT  = 3'd0;
    localparam logic [2:0] P_RIGHT = 3'd1;
    localparam logic [2:0] P_SUM   = 3'd2;
    localparam logic [2:0] P_DIFF  = 3'd3;
    localparam logic [2:0] P_CNEW  = 3'd4;
    localparam logic [2:0] P_COLD  = 3'd5;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_LOAD, S_MSET, S_MUL, S_ACC, S_CHK, S_WDIV,
        S_CSET, S_WMUL, S_SQRT, S_RSET, S_CDIV, S_EMIT
    } t_state;

    t_state r_state;

    // Configuration
    logic [14:0] r_window;
    logic [15:0] r_update;
    logic        r_mono;

    // Frame state
    logic [AW-1:0]          r_wpos;
    logic [AW-1:0]          r_pos;
    logic [AW-1:0]          r_clr;
    logic [15:0]            r_fsu;
    logic [SW-1:0]          r_sum [5];
    logic signed [OPW-1:0]  r_l, r_r, r_ol, r_or;

    // Digit-serial multiplier
    logic [2:0]     r_pidx;
    logic [6:0]     r_cnt;
    logic [PW-1:0]  r_ma;
    logic [OPW-1:0] r_mb;
    logic [PW-1:0]  r_acc;
    logic           r_neg;

    // Result path
    logic [2*SW-1:0] r_wa, r_wacc;
    logic [SW-1:0]   r_wb;
    logic [SW+1:0]   r_rem;
    logic [SW-1:0]   r_root;
    logic [SW-1:0]   r_dnum, r_dden;
    logic [15:0]     r_q;
    logic            r_wv, r_cv, r_cneg;
    logic [scwm_pkg::WIDTH_W-1:0] r_wq, r_cmag;

    // Output slot
    logic                          r_ovalid;
    logic                          r_owv, r_ocv;
    logic [scwm_pkg::WIDTH_W-1:0]  r_ow;
    logic [scwm_pkg::CORR_W-1:0]   r_oc;

    // Sample ring
    logic [2*SAMPLE_BITS-1:0] r_ring [WINDOW_DEPTH];
    logic [2*SAMPLE_BITS-1:0] r_rdata;

    // Effective window length and write position
    logic [CW-1:0] len, win_ext;
    logic [AW-1:0] pos_eff, pos_next;
    always_comb begin
        win_ext = CW'(r_window);
        if (win_ext == '0) begin
            len = CW'(1);
        end else if (win_ext > CW'(WINDOW_DEPTH)) begin
            len = CW'(WINDOW_DEPTH);
        end else begin
            len = win_ext;
        end
        pos_eff  = (CW'(r_wpos) >= len) ? '0 : r_wpos;
        pos_next = (CW'(r_pos) + CW'(1) >= len) ? '0 : r_pos + AW'(1);
    end

    // Input samples, mono copies left into right
    logic signed [OPW-1:0] in_l, in_r;
    assign in_l = OPW'($signed(s_axis_tdata[SAMPLE_BITS-1:0]));
    assign in_r = r_mono ? in_l
                : OPW'($signed(s_axis_tdata[scwm_pkg::FIELD_BITS +: SAMPLE_BITS]));

    // Operand select for the current product
    logic signed [OPW-1:0] s_new, s_old, d_new, d_old, op_a, op_b;
    logic [2:0] tgt;
    always_comb begin
        s_new = r_l + r_r;
        s_old = r_ol + r_or;
        d_new = r_l - r_r;
        d_old = r_ol - r_or;
        case (r_pidx)
            P_LEFT:  begin op_a = r_l - r_ol;   op_b = r_l + r_ol;   end
            P_RIGHT: begin op_a = r_r - r_or;   op_b = r_r + r_or;   end
            P_SUM:   begin op_a = s_new - s_old; op_b = s_new + s_old; end
            P_DIFF:  begin op_a = d_new - d_old; op_b = d_new + d_old; end
            P_CNEW:  begin op_a = r_l;  op_b = r_r;  end
            default: begin op_a = r_ol; op_b = r_or; end
        endcase
        tgt = (r_pidx >= P_CNEW) ? P_CNEW : r_pidx;
    end

    // Signed term for the running sum
    logic [SW-1:0] term;
    assign term = r_neg ? (SW'(0) - SW'(r_acc)) : SW'(r_acc);

    // Restoring divide step, shared by width and correlation
    logic [SW:0]  div_r2;
    logic         div_take;
    logic [SW-1:0] div_rn;
    always_comb begin
        div_r2   = {r_dnum, 1'b0};
        div_take = (div_r2 >= {1'b0, r_dden});
        div_rn   = div_take ? SW'(div_r2 - {1'b0, r_dden}) : SW'(div_r2);
    end

    // Square root step
    logic [SW+1:0] sq_rem, sq_trial;
    logic          sq_take;
    always_comb begin
        sq_rem   = {r_rem[SW-1:0], r_wacc[2*SW-1 -: 2]};
        sq_trial = {r_root, 2'b01};
        sq_take  = (sq_rem >= sq_trial);
    end

    // Result setup values
    logic [SW-1:0] total, cmag;
    logic [15:0]   fsu_inc, period;
    assign total   = r_sum[P_SUM] + r_sum[P_DIFF];
    assign cmag    = r_sum[P_CNEW][SW-1] ? (SW'(0) - r_sum[P_CNEW]) : r_sum[P_CNEW];
    assign fsu_inc = r_fsu + 16'd1;
    assign period  = (r_update == '0) ? 16'd1 : r_update;

    logic accept, cfg_wr;
    assign accept = s_axis_tvalid && s_axis_tready;
    assign cfg_wr = i_cfg_valid && o_cfg_ready;

    // Ring write and registered read
    always_ff @(posedge i_clk) begin
        if (r_state == S_CLR) begin
            r_ring[r_clr] <= '0;
        end else if (r_state == S_LOAD) begin
            r_ring[r_pos] <= {r_r[SAMPLE_BITS-1:0], r_l[SAMPLE_BITS-1:0]};
        end
        r_rdata <= r_ring[pos_eff];
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_window <= scwm_pkg::WINDOW_RESET;
            r_update <= scwm_pkg::UPDATE_RESET;
            r_mono   <= 1'b0;
            r_wpos   <= '0;
            r_fsu    <= '0;
            r_ovalid <= 1'b0;
            for (int i = 0; i < 5; i++) r_sum[i] <= '0;
        end else begin
            // Fill the slot from the emit step, drop it once the receiver takes it
            if ((r_state == S_EMIT) && (!r_ovalid || m_axis_tready)) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tvalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end

            if (cfg_wr && (i_cfg_index == scwm_pkg::REG_WINDOW)) begin
                // A window write restarts the clearing pass
                r_window <= i_cfg_data[14:0];
                r_state  <= S_CLR;
                r_clr    <= '0;
                r_wpos   <= '0;
                r_fsu    <= '0;
                for (int i = 0; i < 5; i++) r_sum[i] <= '0;
            end else begin
                unique case (r_state)
                    S_CLR: begin
                        if (r_clr == AW'(WINDOW_DEPTH - 1)) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_clr <= r_clr + AW'(1);
                        end
                    end
                    S_IDLE: begin
                        if (accept) begin
                            if (s_axis_tuser[0] == scwm_pkg::CMD_CLEAR) begin
                                r_state <= S_CLR;
                                r_clr   <= '0;
                                r_wpos  <= '0;
                                r_fsu   <= '0;
                                for (int i = 0; i < 5; i++) r_sum[i] <= '0;
                            end else begin
                                r_l     <= in_l;
                                r_r     <= in_r;
                                r_pos   <= pos_eff;
                                r_state <= S_LOAD;
                            end
                        end
                    end
                    S_LOAD: begin
                        r_ol    <= OPW'($signed(r_rdata[SAMPLE_BITS-1:0]));
                        r_or    <= OPW'($signed(r_rdata[2*SAMPLE_BITS-1:SAMPLE_BITS]));
                        r_wpos  <= pos_next;
                        r_pidx  <= P_LEFT;
                        r_state <= S_MSET;
                    end
                    S_MSET: begin
                        r_ma    <= PW'(op_a[OPW-1] ? -op_a : op_a);
                        r_mb    <= op_b[OPW-1] ? OPW'(-op_b) : OPW'(op_b);
                        r_neg   <= op_a[OPW-1] ^ op_b[OPW-1] ^ (r_pidx == P_COLD);
                        r_acc   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_MUL;
                    end
                    S_MUL: begin
                        // One digit of the multiplier per cycle
                        r_acc <= r_acc + PW'(r_ma * r_mb[DW-1:0]);
                        r_ma  <= r_ma << DW;
                        r_mb  <= r_mb >> DW;
                        r_cnt <= r_cnt + 7'd1;
                        if (r_cnt == 7'(NDIG - 1)) begin
                            r_state <= S_ACC;
                        end
                    end
                    S_ACC: begin
                        r_sum[tgt] <= r_sum[tgt] + term;
                        if (r_pidx == P_COLD) begin
                            r_state <= S_CHK;
                        end else begin
                            r_pidx  <= r_pidx + 3'd1;
                            r_state <= S_MSET;
                        end
                    end
                    S_CHK: begin
                        if (fsu_inc < period && fsu_inc != '0) begin
                            r_fsu   <= fsu_inc;
                            r_state <= S_IDLE;
                        end else begin
                            r_fsu  <= '0;
                            r_wv   <= (total != '0);
                            r_q    <= '0;
                            r_cnt  <= '0;
                            r_dnum <= r_sum[P_DIFF];
                            r_dden <= total;
                            if (total == '0) begin
                                r_wq    <= '0;
                                r_state <= S_CSET;
                            end else if (r_sum[P_DIFF] >= total) begin
                                r_wq    <= scwm_pkg::ONE_Q16;
                                r_state <= S_CSET;
                            end else begin
                                r_state <= S_WDIV;
                            end
                        end
                    end
                    S_WDIV: begin
                        r_dnum <= div_rn;
                        r_q    <= {r_q[14:0], div_take};
                        r_cnt  <= r_cnt + 7'd1;
                        if (r_cnt == 7'd15) begin
                            r_wq    <= {1'b0, r_q[14:0], div_take};
                            r_state <= S_CSET;
                        end
                    end
                    S_CSET: begin
                        r_cv   <= (r_sum[P_LEFT] != '0) && (r_sum[P_RIGHT] != '0);
                        r_cneg <= r_sum[P_CNEW][SW-1];
                        r_wa   <= (2*SW)'(r_sum[P_LEFT]);
                        r_wb   <= r_sum[P_RIGHT];
                        r_wacc <= '0;
                        r_cnt  <= '0;
                        if ((r_sum[P_LEFT] != '0) && (r_sum[P_RIGHT] != '0)) begin
                            r_state <= S_WMUL;
                        end else begin
                            r_cmag  <= '0;
                            r_state <= S_EMIT;
                        end
                    end
                    S_WMUL: begin
                        // Energy product, one digit per cycle
                        r_wacc <= r_wacc + (2*SW)'(r_wa * r_wb[DW-1:0]);
                        r_wa   <= r_wa << DW;
                        r_wb   <= r_wb >> DW;
                        if (r_cnt == 7'(WIDE_STEPS - 1)) begin
                            r_rem   <= '0;
                            r_root  <= '0;
                            r_cnt   <= '0;
                            r_state <= S_SQRT;
                        end else begin
                            r_cnt <= r_cnt + 7'd1;
                        end
                    end
                    S_SQRT: begin
                        // One root bit per cycle
                        r_rem  <= sq_take ? (sq_rem - sq_trial) : sq_rem;
                        r_root <= {r_root[SW-2:0], sq_take};
                        r_wacc <= r_wacc << 2;
                        r_cnt  <= r_cnt + 7'd1;
                        if (r_cnt == 7'(SW - 1)) begin
                            r_state <= S_RSET;
                        end
                    end
                    S_RSET: begin
                        r_dnum <= cmag;
                        r_dden <= r_root;
                        r_q    <= '0;
                        r_cnt  <= '0;
                        if (cmag >= r_root) begin
                            r_cmag  <= scwm_pkg::ONE_Q16;
                            r_state <= S_EMIT;
                        end else begin
                            r_state <= S_CDIV;
                        end
                    end
                    S_CDIV: begin
                        r_dnum <= div_rn;
                        r_q    <= {r_q[14:0], div_take};
                        r_cnt  <= r_cnt + 7'd1;
                        if (r_cnt == 7'd15) begin
                            r_cmag  <= {1'b0, r_q[14:0], div_take};
                            r_state <= S_EMIT;
                        end
                    end
                    S_EMIT: begin
                        // Load the slot when it is free or being taken
                        if (!r_ovalid || m_axis_tready) begin
                            r_owv    <= r_wv;
                            r_ocv    <= r_cv;
                            r_ow     <= r_wq;
                            r_oc     <= r_cneg ? (scwm_pkg::CORR_W'(0) - {1'b0, r_cmag})
                                               : {1'b0, r_cmag};
                            r_state  <= S_IDLE;
                        end
                    end
                    default: r_state <= S_IDLE;
                endcase
            end

            // Remaining configuration writes
            if (cfg_wr) begin
                case (i_cfg_index)
                    scwm_pkg::REG_UPDATE: r_update <= i_cfg_data;
                    scwm_pkg::REG_MONO:   r_mono   <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = {r_ocv, r_owv};
    assign m_axis_tdata  = {{(scwm_pkg::OUT_DATA_W - scwm_pkg::WIDTH_W
                             - scwm_pkg::CORR_W){1'b0}}, r_oc, r_ow};

endmodule

>>> rtl/scwm_checker.sv
// Port checker for the stereo meter, bound to the top level.
`include "stereo_correlation_width_meter_assert.svh"

module scwm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // A stalled result holds its payload
    `SCWM_ASSERT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

    // Width never exceeds 1.0 and is zero when flagged invalid
    `SCWM_ASSERT(a_width_range, i_clk, i_rst_n, m_axis_tvalid |-> (m_axis_tdata[16:0] <= scwm_pkg::ONE_Q16) && (m_axis_tuser[0] || m_axis_tdata[16:0] == 17'd0), "width out of range")

    // Correlation stays within plus or minus one
    `SCWM_ASSERT(a_corr_range, i_clk, i_rst_n, m_axis_tvalid |-> ($signed(m_axis_tdata[34:17]) <= 18'sd65536) && ($signed(m_axis_tdata[34:17]) >= -18'sd65536), "correlation out of range")

    // Invalid correlation reads zero
    `SCWM_ASSERT(a_corr_zero, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser[1] |-> m_axis_tdata[34:17] == 18'd0, "invalid correlation not zero")

    // Reset empties the output slot
    `SCWM_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !m_axis_tvalid, "result present after reset")

endmodule

bind stereo_correlation_width_meter scwm_checker u_scwm_checker (.*);

>>> tb/sv/stereo_correlation_width_meter_tb.sv
// Self-checking testbench for the stereo correlation and width meter.
`timescale 1ns / 1ps

module stereo_correlation_width_meter_tb;

    localparam int DEPTH = 16384;

    typedef struct packed {
        logic                               width_ok;
        logic [scwm_pkg::WIDTH_W-1:0]       width_q16;
        logic                               corr_ok;
        logic signed [scwm_pkg::CORR_W-1:0] corr_q16;
    } t_meas;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             s_axis_tvalid;
    logic                             s_axis_tready;
    logic [scwm_pkg::IN_DATA_W-1:0]   s_axis_tdata;
    logic [0:0]                       s_axis_tuser;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready;
    logic [scwm_pkg::OUT_DATA_W-1:0]  m_axis_tdata;
    logic [1:0]                       m_axis_tuser;
    logic                             i_cfg_valid;
    logic                             o_cfg_ready;
    logic [1:0]                       i_cfg_index;
    logic [15:0]                      i_cfg_data;

    stereo_correlation_width_meter u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // Mirror of the meter state
    logic signed [23:0] hist_l [DEPTH];
    logic signed [23:0] hist_r [DEPTH];
    int unsigned        wr_pos;
    int unsigned        frame_cnt;
    logic [63:0]        e_ll, e_rr, e_lr, e_sum, e_diff;
    int unsigned        win_cfg, upd_cfg, mono_cfg;

    t_meas       pending_meas[$];
    int          err_cnt = 0;
    int          frames_sent;
    int          clears_sent;
    int          meas_seen = 0;
    bit          idle_en;
    bit          hold_go;
    bit          rx_hold;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Overall time limit
    initial begin
        #30ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic logic [63:0] sq64(longint x);
        return x * x;
    endfunction

    // floor(num * 2^16 / den), saturated at one
    function automatic logic [16:0] ratio_q16(logic [63:0] num, logic [63:0] den);
        logic [127:0] wide;
        if (num >= den) return scwm_pkg::ONE_Q16;
        wide = {64'd0, num} << 16;
        return 17'(wide / {64'd0, den});
    endfunction

    function automatic logic [63:0] root_of(logic [127:0] v);
        logic [63:0]  root;
        logic [63:0]  cand;
        logic [127:0] c2;
        root = '0;
        for (int b = 63; b >= 0; b--) begin
            cand = root | (64'd1 << b);
            c2   = {64'd0, cand} * {64'd0, cand};
            if (c2 <= v) root = cand;
        end
        return root;
    endfunction

    task automatic wipe_meter();
        for (int k = 0; k < DEPTH; k++) begin
            hist_l[k] = '0;
            hist_r[k] = '0;
        end
        wr_pos = 0; frame_cnt = 0;
        e_ll = '0; e_rr = '0; e_lr = '0; e_sum = '0; e_diff = '0;
    endtask

    // Advance the mirror by one accepted request
    task automatic meter_step(logic cmd, logic [23:0] ls, logic [23:0] rs);
        int unsigned len, pos, period;
        longint      l, r, ol, orr;
        logic [63:0] total, den, mag;
        logic [16:0] q;
        logic        neg;
        t_meas       m;
        if (cmd == scwm_pkg::CMD_CLEAR) begin
            wipe_meter();
            return;
        end
        len = (win_cfg < 1) ? 1 : (win_cfg > DEPTH ? DEPTH : win_cfg);
        pos = (wr_pos >= len) ? 0 : wr_pos;
        l   = longint'($signed(ls));
        r   = mono_cfg ? l : longint'($signed(rs));
        ol  = longint'(hist_l[pos]);
        orr = longint'(hist_r[pos]);
        e_ll   += sq64(l) - sq64(ol);
        e_rr   += sq64(r) - sq64(orr);
        e_lr   += 64'(l * r) - 64'(ol * orr);
        e_sum  += sq64(l + r) - sq64(ol + orr);
        e_diff += sq64(l - r) - sq64(ol - orr);
        hist_l[pos] = 24'(l);
        hist_r[pos] = 24'(r);
        wr_pos = (pos + 1 >= len) ? 0 : pos + 1;
        period = (upd_cfg < 1) ? 1 : upd_cfg;
        frame_cnt = (frame_cnt + 1) & 16'hFFFF;
        if (frame_cnt < period && frame_cnt != 0) return;
        frame_cnt = 0;
        m = '0;
        total = e_sum + e_diff;
        if (total > 0) begin
            m.width_ok  = 1'b1;
            m.width_q16 = ratio_q16(e_diff, total);
        end
        if (e_ll > 0 && e_rr > 0) begin
            neg = e_lr[63];
            den = root_of({64'd0, e_ll} * {64'd0, e_rr});
            mag = neg ? (~e_lr + 64'd1) : e_lr;
            q   = ratio_q16(mag, den);
            m.corr_ok  = 1'b1;
            m.corr_q16 = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
        end
        pending_meas.push_back(m);
    endtask

    // Long receiver hold-off, counted in cycles here
    initial begin
        rx_hold = 1'b0;
        @(posedge hold_go);
        @(negedge i_clk);
        rx_hold = 1'b1;
        repeat (3000) @(negedge i_clk);
        rx_hold = 1'b0;
    end

    // Receiver ready: random stall bursts plus the long hold-off
    int stall_left = 0;
    always @(negedge i_clk) begin
        if (rx_hold) begin
            m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (idle_en && $urandom_range(0, 5) == 0) begin
            m_axis_tready <= 1'b0;
            stall_left <= $urandom_range(0, 4);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Compare each accepted measurement with the oldest expected one
    always @(posedge i_clk) begin
        t_meas e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            meas_seen++;
            if (pending_meas.size() == 0) begin
                $error("unexpected measurement: tuser=%b tdata=%h", m_axis_tuser, m_axis_tdata);
                err_cnt++;
            end else begin
                e = pending_meas.pop_front();
                if (m_axis_tuser[0] !== e.width_ok) begin
                    $error("width_valid: expected %0d actual %0d", e.width_ok, m_axis_tuser[0]);
                    err_cnt++;
                end
                if (m_axis_tdata[16:0] !== e.width_q16) begin
                    $error("stereo_width: expected %0d actual %0d",
                           e.width_q16, m_axis_tdata[16:0]);
                    err_cnt++;
                end
                if (m_axis_tuser[1] !== e.corr_ok) begin
                    $error("correlation_valid: expected %0d actual %0d",
                           e.corr_ok, m_axis_tuser[1]);
                    err_cnt++;
                end
                if (m_axis_tdata[34:17] !== e.corr_q16) begin
                    $error("correlation: expected %0d actual %0d",
                           e.corr_q16, $signed(m_axis_tdata[34:17]));
                    err_cnt++;
                end
            end
        end
    end

    // Send one request and hold until it is taken
    task automatic send_req(logic cmd, logic [23:0] ls, logic [23:0] rs);
        int gap;
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = cmd;
        s_axis_tdata  = {rs, ls};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        meter_step(cmd, ls, rs);
        if (cmd == scwm_pkg::CMD_CLEAR) clears_sent++; else frames_sent++;
        if (idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 5);
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic send_frame(logic [23:0] ls, logic [23:0] rs);
        send_req(scwm_pkg::CMD_FRAME, ls, rs);
    endtask

    // Wait until all measurements are in and the block has gone quiet
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending_meas.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        // Hold off until the request in flight has finished
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            scwm_pkg::REG_WINDOW: begin
                win_cfg = val & 16'h7FFF;
                wipe_meter();
            end
            scwm_pkg::REG_UPDATE: upd_cfg = val;
            scwm_pkg::REG_MONO:   mono_cfg = val & 1;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic logic [23:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'($signed($urandom_range(0, 64)) - 32);
            default: return 24'($urandom);
        endcase
    endfunction

    // Random frames with occasional clears: independent, equal, opposite or silent right channels
    task automatic random_frames(int n);
        logic [23:0] ls, rs;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 199) == 0) begin
                send_req(scwm_pkg::CMD_CLEAR, 24'($urandom), 24'($urandom));
            end else begin
                ls = pick_sample();
                case ($urandom_range(0, 9))
                    0: rs = ls;
                    1: rs = -ls;
                    2: rs = '0;
                    default: rs = pick_sample();
                endcase
                send_frame(ls, rs);
            end
        end
    endtask

    // Extremes at reset settings, the update count lowered mid-count, then window, update and mono cases
    task automatic test_directed();
        send_frame(24'h7FFFFF, 24'h800000);
        send_frame(24'h800000, 24'h800000);
        send_frame(24'h000000, 24'h000000);
        write_reg(scwm_pkg::REG_UPDATE, 16'd1);
        send_frame(24'h000001, 24'hFFFFFF);
        send_frame(24'h7FFFFF, 24'h7FFFFF);
        send_frame(24'h000000, 24'h000000);
        send_req(scwm_pkg::CMD_CLEAR, 24'hFFFFFF, 24'hFFFFFF);
        send_frame(24'h000000, 24'h000000);
        send_frame(24'h000000, 24'h123456);
        send_frame(24'h123456, 24'h000000);
        drain();
        // window zero acts as one, update zero as one
        write_reg(scwm_pkg::REG_WINDOW, 16'd0);
        write_reg(scwm_pkg::REG_UPDATE, 16'd0);
        send_frame(24'h400000, 24'hC00000);
        send_frame(24'h7FFFFF, 24'h7FFFFF);
        drain();
        // oversized window clamps to the ring depth
        write_reg(scwm_pkg::REG_WINDOW, 16'h7FFF);
        write_reg(scwm_pkg::REG_UPDATE, 16'hFFFF);
        for (int k = 0; k < 5; k++) send_frame(24'h800000, 24'h800000);
        write_reg(scwm_pkg::REG_UPDATE, 16'd2);
        send_frame(24'h800000, 24'h7FFFFF);
        write_reg(scwm_pkg::REG_MONO, 16'd1);
        send_frame(24'h7FFFFF, 24'h000000);
        send_frame(24'h800000, 24'h555555);
        drain();
    endtask

    task automatic test_short_window();
        write_reg(scwm_pkg::REG_MONO, 16'd0);
        write_reg(scwm_pkg::REG_WINDOW, 16'd1);
        write_reg(scwm_pkg::REG_UPDATE, 16'd1);
        random_frames(300);
        drain();
        write_reg(scwm_pkg::REG_WINDOW, 16'd7);
        write_reg(scwm_pkg::REG_UPDATE, 16'd3);
        random_frames(300);
        drain();
    endtask

    task automatic test_mono();
        write_reg(scwm_pkg::REG_MONO, 16'd1);
        write_reg(scwm_pkg::REG_WINDOW, 16'd50);
        write_reg(scwm_pkg::REG_UPDATE, 16'd2);
        random_frames(300);
        drain();
    endtask

    // Receiver stalls long enough that the block backs up its input
    task automatic test_backpressure();
        write_reg(scwm_pkg::REG_MONO, 16'd0);
        write_reg(scwm_pkg::REG_UPDATE, 16'd1);
        @(negedge i_clk);
        hold_go = 1'b1;
        random_frames(40);
        drain();
    endtask

    task automatic test_full_window();
        write_reg(scwm_pkg::REG_WINDOW, 16'd16384);
        write_reg(scwm_pkg::REG_UPDATE, 16'd4);
        random_frames(400);
        drain();
        // last stretch with both sides always ready
        idle_en = 1'b0;
        write_reg(scwm_pkg::REG_WINDOW, 16'd300);
        write_reg(scwm_pkg::REG_UPDATE, 16'd1);
        random_frames(350);
        drain();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = scwm_pkg::CMD_FRAME;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = scwm_pkg::REG_WINDOW;
        i_cfg_data    = '0;
        frames_sent = 0; clears_sent = 0;
        idle_en = 1'b1; hold_go = 1'b0;
        win_cfg = scwm_pkg::WINDOW_RESET;
        upd_cfg = scwm_pkg::UPDATE_RESET;
        mono_cfg = 0;
        wipe_meter();
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_short_window();
        test_mono();
        test_backpressure();
        test_full_window();

        $display("Covered %0d frames and %0d clear requests, %0d measurements checked,",
                 frames_sent, clears_sent, meas_seen);
        $display("over window lengths 1 to full depth, stereo and mono, with stalls.");
        if (err_cnt == 0 && pending_meas.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
